// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion helpers clocked on clk; only IU_ASSERT is disabled while arst_n is low.
`ifndef SYNTHESIS
`define IU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define IU_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define IU_ASSERT(lbl, prop, msg)
`define IU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/iu7u8_pkg.sv =====
package iu7u8_pkg;

	typedef enum logic [1:0] {
		MODE_LITERAL = 2'd0,
		MODE_AMP     = 2'd1,
		MODE_B64     = 2'd2
	} mode_t;

	localparam logic [7:0] ASCII_AMP   = 8'h26;
	localparam logic [7:0] ASCII_DASH  = 8'h2D;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_COMMA = 8'h2C;

	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

	localparam int unsigned MAX_RESULTS = 4;

	// Modified base64 digit value; bit 6 set means not in the alphabet.
	function automatic logic [6:0] b64_value(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd64;
		if (b >= 8'h41 && b <= 8'h5A)
			d = b - 8'd65;
		else if (b >= 8'h61 && b <= 8'h7A)
			d = b - 8'd71;
		else if (b >= 8'h30 && b <= 8'h39)
			d = b + 8'd4;
		else if (b == ASCII_PLUS)
			d = 8'd62;
		else if (b == ASCII_COMMA)
			d = 8'd63;
		return d[6:0];
	endfunction

endpackage

// ===== sv/iu7u8_in_if.sv =====
interface iu7u8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_name;

	modport source (output valid, output in_byte, output start_of_name, input ready);
	modport sink (input valid, input in_byte, input start_of_name, output ready);
endinterface

// ===== sv/iu7u8_out_if.sv =====
interface iu7u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== sv/imap_utf7_to_utf8_decoder.sv =====
// Channel   Direction  Beat payload
// utf7      sink       in_byte[7:0], start_of_name
// utf8      source     out_byte[7:0], last_of_run
//
// An input beat is decoded in the cycle it is accepted; its 0 to 4 UTF-8
// bytes go into a four-entry result register and leave one per cycle
// while utf8 is ready. How long one input byte holds utf7 off is set by the
// single-byte result port; after a byte that yields nothing, utf7 stays ready.
// A new beat is taken while the last pending result byte is being taken.
// arst_n clears mode, bit buffer, bit count, partial code point and the
// pending count; a stalled utf8 holds the result register and blocks utf7.

`include "assert_macros.svh"

module imap_utf7_to_utf8_decoder import iu7u8_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	iu7u8_in_if.sink         utf7,
	iu7u8_out_if.source      utf8
);

	mode_t       mode_q, mode_d, mode_cur;
	logic [15:0] bbuf_q, bbuf_d;
	logic [3:0]  bcnt_q, bcnt_d;
	logic [31:0] pcp_q, pcp_d;
	logic [7:0]  obuf_q [MAX_RESULTS];
	logic [2:0]  rem_q;

	logic        in_acc, out_take;
	logic [7:0]  b;
	logic [6:0]  v;
	logic        is_alpha, is_dash, step_b64, open_sec;
	logic [15:0] base_buf;
	logic [3:0]  base_cnt;
	logic [31:0] base_pcp;
	logic [19:0] tmp;
	logic [4:0]  cnt6;
	logic        unit_full;
	logic [15:0] unit;
	logic        is_hi, is_lo, emit_cp;
	logic [31:0] cp;
	logic [2:0]  res_n;
	logic [7:0]  res [MAX_RESULTS];

	assign b        = utf7.in_byte;
	assign v        = b64_value(b);
	assign is_alpha = ~v[6];
	assign is_dash  = (b == ASCII_DASH);
	assign mode_cur = utf7.start_of_name ? MODE_LITERAL : mode_q;

	assign out_take   = utf8.valid && utf8.ready;
	assign utf7.ready = (rem_q == 3'd0) || (out_take && rem_q == 3'd1);
	assign in_acc     = utf7.valid && utf7.ready;

	assign utf8.valid       = (rem_q != 3'd0);
	assign utf8.out_byte    = obuf_q[0];
	assign utf8.last_of_run = (rem_q == 3'd1);

	// next mode
	always_comb begin
		unique case (mode_cur)
			MODE_AMP: begin
				if (is_dash)
					mode_d = MODE_LITERAL;
				else if (is_alpha)
					mode_d = MODE_B64;
				else
					mode_d = (b == ASCII_AMP) ? MODE_AMP : MODE_LITERAL;
			end
			MODE_B64: begin
				if (is_alpha)
					mode_d = MODE_B64;
				else if (is_dash)
					mode_d = MODE_LITERAL;
				else
					mode_d = (b == ASCII_AMP) ? MODE_AMP : MODE_LITERAL;
			end
			default: begin
				mode_d = (b == ASCII_AMP) ? MODE_AMP : MODE_LITERAL;
			end
		endcase
	end

	// base64 digit step and surrogate handling
	always_comb begin
		step_b64 = is_alpha && (mode_cur == MODE_AMP || mode_cur == MODE_B64);
		open_sec = is_alpha && (mode_cur == MODE_AMP);
		base_buf = open_sec ? 16'd0 : bbuf_q;
		base_cnt = open_sec ? 4'd0 : bcnt_q;
		base_pcp = open_sec ? 32'd0 : pcp_q;

		tmp       = {base_buf[13:0], v[5:0]};
		cnt6      = {1'b0, base_cnt} + 5'd6;
		unit_full = cnt6[4];
		unit      = 16'(tmp >> cnt6[3:0]);
		is_hi     = (unit[15:10] == SURR_HIGH_TAG);
		is_lo     = (unit[15:10] == SURR_LOW_TAG);

		if (!unit_full)
			cp = base_pcp;
		else if (is_hi)
			cp = {12'd0, unit[9:0], 10'd0};
		else if (is_lo)
			cp = base_pcp + {15'd0, 1'b1, 6'd0, unit[9:0]};
		else
			cp = {16'd0, unit};
		emit_cp = unit_full && !is_hi;

		if (step_b64) begin
			bbuf_d = tmp[15:0];
			bcnt_d = cnt6[3:0];
			pcp_d  = cp;
		end else begin
			bbuf_d = bbuf_q;
			bcnt_d = bcnt_q;
			pcp_d  = pcp_q;
		end
	end

	// result bytes for this beat
	always_comb begin
		res_n = 3'd0;
		for (int i = 0; i < MAX_RESULTS; i++)
			res[i] = 8'd0;
		if (step_b64) begin
			if (emit_cp) begin
				if (cp <= 32'h7F) begin
					res_n  = 3'd1;
					res[0] = cp[7:0];
				end else if (cp <= 32'h7FF) begin
					res_n  = 3'd2;
					res[0] = {3'b110, cp[10:6]};
					res[1] = {2'b10, cp[5:0]};
				end else if (cp <= 32'hFFFF) begin
					res_n  = 3'd3;
					res[0] = {4'b1110, cp[15:12]};
					res[1] = {2'b10, cp[11:6]};
					res[2] = {2'b10, cp[5:0]};
				end else begin
					res_n  = 3'd4;
					res[0] = 8'hF0 | cp[25:18];
					res[1] = {2'b10, cp[17:12]};
					res[2] = {2'b10, cp[11:6]};
					res[3] = {2'b10, cp[5:0]};
				end
			end
		end else if (mode_cur == MODE_AMP && is_dash) begin
			res_n  = 3'd1;
			res[0] = ASCII_AMP;
		end else if (mode_cur == MODE_B64 && is_dash) begin
			res_n = 3'd0;
		end else if (b != ASCII_AMP) begin
			res_n  = 3'd1;
			res[0] = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LITERAL;
			bbuf_q <= 16'd0;
			bcnt_q <= 4'd0;
			pcp_q  <= 32'd0;
			rem_q  <= 3'd0;
		end else begin
			if (in_acc) begin
				mode_q <= mode_d;
				bbuf_q <= bbuf_d;
				bcnt_q <= bcnt_d;
				pcp_q  <= pcp_d;
				rem_q  <= res_n;
			end else if (out_take) begin
				rem_q <= rem_q - 3'd1;
			end
		end
	end

	// load on accept, otherwise advance one byte per taken beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MAX_RESULTS; i++)
				obuf_q[i] <= res[i];
		end else if (out_take) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++)
				obuf_q[i] <= obuf_q[i + 1];
			obuf_q[MAX_RESULTS - 1] <= 8'd0;
		end
	end

	`IU_ASSERT(a_no_overwrite, in_acc |-> (rem_q == 3'd0 || (out_take && rem_q == 3'd1)), "input beat taken over pending results")
	`IU_ASSERT(a_start_literal, (in_acc && utf7.start_of_name && utf7.in_byte != ASCII_AMP) |=> (rem_q == 3'd1 && obuf_q[0] == $past(utf7.in_byte)), "literal byte after start flag not passed through")
	`IU_ASSERT(a_dash_close, (in_acc && !utf7.start_of_name && mode_q == MODE_B64 && utf7.in_byte == ASCII_DASH) |=> (mode_q == MODE_LITERAL && rem_q == 3'd0), "dash did not close the section silently")
	`IU_ASSERT_RST(a_even_count, bcnt_q[0] == 1'b0, "bit count went odd")

endmodule
